>>> design/gcr_pkg.sv
// Shared constants, types and the color palette of the glyph cell renderer.
package gcr_pkg;

    localparam int GLYPH_ROWS   = 14;
    localparam int GLYPH_COUNT  = 256;
    localparam int FONT_DEPTH   = GLYPH_ROWS * GLYPH_COUNT;
    localparam int FONT_AW      = $clog2(FONT_DEPTH);
    localparam int ROW_W        = $clog2(GLYPH_ROWS);
    localparam int CELL_WIDTH   = 8;
    localparam int CURSOR_FIRST = GLYPH_ROWS - 3;

    localparam int OFF_W   = 32;
    localparam int COLOR_W = 24;
    localparam int PITCH_W = 16;
    localparam int ORG_W   = 12;
    localparam int CELL_W  = 8;
    localparam int BITS_W  = 8;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 16;
    localparam int Y_W     = 13;
    localparam int X_W     = 13;

    localparam logic [COLOR_W-1:0] CURSOR_GREY = 24'hC0C0C0;
    localparam logic [BITS_W-1:0]  ALL_PIXELS  = 8'hFF;

    // input item modes
    localparam logic [1:0] MODE_CHAR   = 2'd0;
    localparam logic [1:0] MODE_CURSOR = 2'd1;
    localparam logic [1:0] MODE_LOAD   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_LINE_PITCH = 3'd2;
    localparam logic [CFG_IW-1:0] REG_GRID_COLS  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_GRID_ROWS  = 3'd4;

    // work kinds passed from front to back
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_DRAW   = 2'd1;
    localparam logic [1:0] KIND_CURSOR = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]         kind;
        logic [OFF_W-1:0]   offset;
        logic [PITCH_W-1:0] pitch;
        logic [COLOR_W-1:0] fore;
        logic [COLOR_W-1:0] back;
        logic               transparent;
        logic [FONT_AW-1:0] font_addr;
        logic [BITS_W-1:0]  font_bits;
        logic [ROW_W-1:0]   first_row;
    } t_entry;

    function automatic logic [COLOR_W-1:0] palette_color(input logic [3:0] idx);
        logic [COLOR_W-1:0] c;
        unique case (idx)
            4'd0:    c = 24'h000000;
            4'd1:    c = 24'h000080;
            4'd2:    c = 24'h008000;
            4'd3:    c = 24'h008080;
            4'd4:    c = 24'h800000;
            4'd5:    c = 24'h800080;
            4'd6:    c = 24'h808000;
            4'd7:    c = 24'hC0C0C0;
            4'd8:    c = 24'h808080;
            4'd9:    c = 24'h0000FF;
            4'd10:   c = 24'h00FF00;
            4'd11:   c = 24'h00FFFF;
            4'd12:   c = 24'hFF0000;
            4'd13:   c = 24'hFF00FF;
            4'd14:   c = 24'hFFFF00;
            default: c = 24'hFFFFFF;
        endcase
        return c;
    endfunction

endpackage

>>> design/gcr_front.sv
// Front end: config registers, item intake, clipping, palette and cell address.
module gcr_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [gcr_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [gcr_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_mode,
    input  logic [7:0]                  i_cell_col,
    input  logic [7:0]                  i_cell_row,
    input  logic [3:0]                  i_fore_index,
    input  logic [3:0]                  i_back_index,
    input  logic                        i_transparent,
    input  logic [7:0]                  i_char_code,
    input  logic                        i_insert_cursor,
    input  logic                        i_cursor_visible,
    input  logic [11:0]                 i_font_addr,
    input  logic [7:0]                  i_font_bits,
    output logic                        o_push,
    input  logic                        i_push_ready,
    output gcr_pkg::t_entry             o_entry
);
    import gcr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ADDR = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_PUSH = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [ORG_W-1:0]   r_origin_x, r_origin_y;
    logic [PITCH_W-1:0] r_pitch;
    logic [CELL_W-1:0]  r_grid_cols, r_grid_rows;

    logic [1:0]         r_mode;
    logic [CELL_W-1:0]  r_col, r_row;
    logic [3:0]         r_fore_idx, r_back_idx;
    logic               r_transp, r_insert, r_visible;
    logic [7:0]         r_char;
    logic [FONT_AW-1:0] r_faddr;
    logic [BITS_W-1:0]  r_fbits;

    logic [Y_W-1:0]     r_y;
    logic [X_W-1:0]     r_x;
    logic               r_rej;
    logic [ROW_W-1:0]   r_first;
    logic [COLOR_W-1:0] r_fore, r_back;
    logic [OFF_W-1:0]   r_base;

    logic               accept;
    logic               off_grid;
    logic [ROW_W-1:0]   first;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign accept      = i_valid && o_ready;
    assign off_grid    = (r_col >= r_grid_cols) || (r_row >= r_grid_rows);
    assign first       = (r_mode == MODE_CURSOR && !r_insert) ?
                         ROW_W'(CURSOR_FIRST) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_pitch     <= PITCH_W'(4096);
            r_grid_cols <= CELL_W'(100);
            r_grid_rows <= CELL_W'(40);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ORIGIN_X:   r_origin_x  <= i_cfg_data[ORG_W-1:0];
                REG_ORIGIN_Y:   r_origin_y  <= i_cfg_data[ORG_W-1:0];
                REG_LINE_PITCH: r_pitch     <= i_cfg_data[PITCH_W-1:0];
                REG_GRID_COLS:  r_grid_cols <= i_cfg_data[CELL_W-1:0];
                REG_GRID_ROWS:  r_grid_rows <= i_cfg_data[CELL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_mode == MODE_LOAD) begin
                        if (32'(i_font_addr) < FONT_DEPTH) n_state = S_PUSH;
                    end else if (i_mode == MODE_CHAR || i_mode == MODE_CURSOR) begin
                        n_state = S_ADDR;
                    end
                end
            end
            S_ADDR:  n_state = S_MUL;
            S_MUL:   n_state = S_PUSH;
            S_PUSH:  if (i_push_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // item capture; a draw item swaps the font address for its glyph base
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode     <= i_mode;
            r_col      <= i_cell_col;
            r_row      <= i_cell_row;
            r_fore_idx <= i_fore_index;
            r_back_idx <= i_back_index;
            r_transp   <= i_transparent;
            r_char     <= i_char_code;
            r_insert   <= i_insert_cursor;
            r_visible  <= i_cursor_visible;
            r_faddr    <= i_font_addr[FONT_AW-1:0];
            r_fbits    <= i_font_bits;
        end else if (r_state == S_ADDR && r_mode == MODE_CHAR) begin
            r_faddr    <= FONT_AW'(r_char % GLYPH_COUNT) * FONT_AW'(GLYPH_ROWS);
        end
    end

    // pixel position of the first emitted row, colors, clip
    always_ff @(posedge i_clk) begin
        if (r_state == S_ADDR) begin
            r_y     <= Y_W'(r_row * GLYPH_ROWS) + Y_W'(r_origin_y) + Y_W'(first);
            r_x     <= X_W'(r_col * CELL_WIDTH) + X_W'(r_origin_x);
            r_rej   <= off_grid;
            r_first <= first;
            if (off_grid) begin
                r_fore <= '0;
                r_back <= '0;
            end else if (r_mode == MODE_CHAR) begin
                r_fore <= palette_color(r_fore_idx);
                r_back <= palette_color(r_back_idx);
            end else begin
                r_fore <= r_visible ? CURSOR_GREY : '0;
                r_back <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            if (r_rej) r_base <= '0;
            else       r_base <= OFF_W'(r_y) * OFF_W'(r_pitch) + OFF_W'({r_x, 2'b00});
        end
    end

    assign o_push = (r_state == S_PUSH);

    always_comb begin
        o_entry.offset      = r_base;
        o_entry.pitch       = r_pitch;
        o_entry.fore        = r_fore;
        o_entry.back        = r_back;
        o_entry.transparent = r_transp;
        o_entry.font_addr   = r_faddr;
        o_entry.font_bits   = r_fbits;
        o_entry.first_row   = r_first;
        if (r_mode == MODE_LOAD)     o_entry.kind = KIND_LOAD;
        else if (r_rej)              o_entry.kind = KIND_REJECT;
        else if (r_mode == MODE_CHAR) o_entry.kind = KIND_DRAW;
        else                         o_entry.kind = KIND_CURSOR;
    end

endmodule

>>> design/gcr_queue.sv
// Small FIFO of work entries between the front and back ends.
module gcr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_push_ready,
    input  gcr_pkg::t_entry i_entry,
    output logic            o_valid,
    input  logic            i_pop,
    output gcr_pkg::t_entry o_entry
);
    import gcr_pkg::*;

    t_entry             r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr, r_rptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push, do_pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid      = (r_count != '0);
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;
    assign o_entry      = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wptr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push)
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            if (do_pop)
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

>>> design/gcr_back.sv
// Back end: font store, row sequencer, font read stage and result register.
module gcr_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_q_pop,
    input  gcr_pkg::t_entry               i_entry,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [gcr_pkg::OFF_W-1:0]     o_byte_offset,
    output logic [gcr_pkg::BITS_W-1:0]    o_glyph_bits,
    output logic [gcr_pkg::BITS_W-1:0]    o_write_mask,
    output logic [gcr_pkg::COLOR_W-1:0]   o_fore_color,
    output logic [gcr_pkg::COLOR_W-1:0]   o_back_color,
    output logic                          o_rejected,
    output logic                          o_last_row
);
    import gcr_pkg::*;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_ROWS - 1);

    logic [BITS_W-1:0]  font_mem [FONT_DEPTH];

    // row sequencer
    logic               r_busy;
    logic [1:0]         r_kind;
    logic [ROW_W-1:0]   r_row;
    logic [FONT_AW-1:0] r_addr;
    logic [OFF_W-1:0]   r_off;
    logic [PITCH_W-1:0] r_pitch;
    logic [COLOR_W-1:0] r_fore, r_back;
    logic               r_transp;

    // font read stage
    logic               r_rd_valid;
    logic [BITS_W-1:0]  r_rd_data;
    logic [1:0]         r_b_kind;
    logic [OFF_W-1:0]   r_b_off;
    logic [COLOR_W-1:0] r_b_fore, r_b_back;
    logic               r_b_transp, r_b_last;

    // result register
    logic               r_out_valid;

    logic out_free, out_mv, issue, fin, pop, pop_load;

    assign out_free = !r_out_valid || i_ready;
    assign out_mv   = r_rd_valid && out_free;
    assign issue    = r_busy && (!r_rd_valid || out_free);
    assign fin      = issue && (r_row == LAST_ROW);
    assign pop      = i_q_valid && (!r_busy || fin);
    assign pop_load = pop && (i_entry.kind == KIND_LOAD);
    assign o_q_pop  = pop;

    always_ff @(posedge i_clk) begin
        if (pop_load) font_mem[i_entry.font_addr] <= i_entry.font_bits;
    end

    always_ff @(posedge i_clk) begin
        if (issue) r_rd_data <= font_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (pop) begin
            r_busy <= !pop_load;
        end else if (fin) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_kind   <= i_entry.kind;
            r_row    <= (i_entry.kind == KIND_REJECT) ? LAST_ROW : i_entry.first_row;
            r_addr   <= i_entry.font_addr;
            r_off    <= i_entry.offset;
            r_pitch  <= i_entry.pitch;
            r_fore   <= i_entry.fore;
            r_back   <= i_entry.back;
            r_transp <= i_entry.transparent;
        end else if (issue) begin
            r_row  <= r_row + 1'b1;
            r_addr <= r_addr + 1'b1;
            r_off  <= r_off + OFF_W'(r_pitch);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)     r_rd_valid <= 1'b0;
        else if (issue)   r_rd_valid <= 1'b1;
        else if (out_mv)  r_rd_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_b_kind   <= r_kind;
            r_b_off    <= r_off;
            r_b_fore   <= r_fore;
            r_b_back   <= r_back;
            r_b_transp <= r_transp;
            r_b_last   <= (r_row == LAST_ROW);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_out_valid <= 1'b0;
        else if (out_free) r_out_valid <= r_rd_valid;
    end

    always_ff @(posedge i_clk) begin
        if (out_mv) begin
            o_byte_offset <= r_b_off;
            o_fore_color  <= r_b_fore;
            o_back_color  <= r_b_back;
            o_last_row    <= r_b_last;
            o_rejected    <= (r_b_kind == KIND_REJECT);
            case (r_b_kind)
                KIND_DRAW: begin
                    o_glyph_bits <= r_rd_data;
                    o_write_mask <= r_b_transp ? r_rd_data : ALL_PIXELS;
                end
                KIND_CURSOR: begin
                    o_glyph_bits <= ALL_PIXELS;
                    o_write_mask <= ALL_PIXELS;
                end
                default: begin
                    o_glyph_bits <= '0;
                    o_write_mask <= '0;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;

endmodule

>>> design/glyph_cell_renderer.sv
// Top level of the text-mode glyph cell renderer (8 x 14 cells, 32-bit pixels).
//
//  channel   direction  handshake                  payload
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//  item      in         i_valid / o_ready          i_mode ... i_font_bits
//  result    out        o_valid / i_ready          o_byte_offset ... o_last_row
//
// Steps: the front end takes a draw or cursor item through capture,
// clip/palette/position, row-address multiply and hand-off, and a font load
// through capture and hand-off. The back end emits one row per cycle, paced by
// the font store read port, while the result register is not stalled; a
// character gives 14 rows, an underline cursor 3, an off-grid cell 1, with no
// gap when the next entry is already queued, and a font load emits no row.
// Reset is synchronous, active low; the font store is not cleared and must be
// loaded before glyphs are drawn. A stalled result holds in the output register
// while the read stage and a 2-entry queue keep the front end taking items.
module glyph_cell_renderer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gcr_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [gcr_pkg::CFG_DW-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_mode,
    input  logic [7:0]                    i_cell_col,
    input  logic [7:0]                    i_cell_row,
    input  logic [3:0]                    i_fore_index,
    input  logic [3:0]                    i_back_index,
    input  logic                          i_transparent,
    input  logic [7:0]                    i_char_code,
    input  logic                          i_insert_cursor,
    input  logic                          i_cursor_visible,
    input  logic [11:0]                   i_font_addr,
    input  logic [7:0]                    i_font_bits,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [gcr_pkg::OFF_W-1:0]     o_byte_offset,
    output logic [gcr_pkg::BITS_W-1:0]    o_glyph_bits,
    output logic [gcr_pkg::BITS_W-1:0]    o_write_mask,
    output logic [gcr_pkg::COLOR_W-1:0]   o_fore_color,
    output logic [gcr_pkg::COLOR_W-1:0]   o_back_color,
    output logic                          o_rejected,
    output logic                          o_last_row
);
    import gcr_pkg::*;

    // front -> queue
    logic   push, push_ready;
    t_entry push_entry;
    // queue -> back
    logic   q_valid, q_pop;
    t_entry q_entry;

    gcr_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_cell_col       (i_cell_col),
        .i_cell_row       (i_cell_row),
        .i_fore_index     (i_fore_index),
        .i_back_index     (i_back_index),
        .i_transparent    (i_transparent),
        .i_char_code      (i_char_code),
        .i_insert_cursor  (i_insert_cursor),
        .i_cursor_visible (i_cursor_visible),
        .i_font_addr      (i_font_addr),
        .i_font_bits      (i_font_bits),
        .o_push           (push),
        .i_push_ready     (push_ready),
        .o_entry          (push_entry)
    );

    // loads travel through the queue too, so they stay ordered with draws
    gcr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_entry      (push_entry),
        .o_valid      (q_valid),
        .i_pop        (q_pop),
        .o_entry      (q_entry)
    );

    gcr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .o_q_pop       (q_pop),
        .i_entry       (q_entry),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_byte_offset (o_byte_offset),
        .o_glyph_bits  (o_glyph_bits),
        .o_write_mask  (o_write_mask),
        .o_fore_color  (o_fore_color),
        .o_back_color  (o_back_color),
        .o_rejected    (o_rejected),
        .o_last_row    (o_last_row)
    );

endmodule
